FILE: src/tpf_pkg.sv
// Package for tour_packing_fitness: widths, register indexes and shared constants.
// No dependencies.
package tpf_pkg;
   localparam int COORD_BITS_DEF     = 16;
   localparam int TIME_FRAC_BITS_DEF = 16;
   localparam int TIME_W   = 48;
   localparam int WORD_W   = 32;
   localparam int IN_W     = 24;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 48;
   localparam logic [CSR_IDX_W-1:0] REG_CAPACITY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SPEED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_TIME  = 2'd3;
   localparam logic [TIME_W-1:0] TIME_ALL = {TIME_W{1'b1}};
endpackage

FILE: src/tpf_stream_if.sv
// Valid/ready stream interface carrying a generic payload.
// Depends on nothing.
interface tpf_stream_if #(parameter int W = 1);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: src/tpf_queue.sv
// Two-entry word queue between front and back.
// Depends on nothing.
module tpf_queue #(parameter int W = 8) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);
   logic [W-1:0] mem_ff [2];
   logic [W-1:0] mem_in [2];
   logic         wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid & in_ready;
   assign pop  = out_valid & out_ready;

   always_comb begin
      mem_in = mem_ff;
      if (push) mem_in[wp_ff] = in_data;
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule

FILE: src/tpf_front.sv
// Front: accepts stop words, computes dx^2+dy^2 and the travel class flags.
// Depends on tpf_pkg and tpf_stream_if.
module tpf_front #(parameter int COORD_BITS = tpf_pkg::COORD_BITS_DEF) (
   input  logic clock,
   input  logic reset,
   tpf_stream_if.sink req,
   output logic                  q_valid,
   input  logic                  q_ready,
   output logic [2*COORD_BITS+1+tpf_pkg::IN_W*2+2:0] q_data
);
   import tpf_pkg::*;
   localparam int SQ_W = 2*COORD_BITS+1;
   logic [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic [COORD_BITS-1:0] x, y, dx, dy;
   logic [IN_W-1:0] w, p;
   logic first, last, travel, mv;
   logic [2*COORD_BITS-1:0] sx, sy;
   logic [SQ_W-1:0] sq;

   // coordinate fields are 16 bits wide on the word, taken mod 2^COORD_BITS
   assign x = COORD_BITS'(req.data[15:0]);
   assign y = COORD_BITS'(req.data[31:16]);
   assign w = req.data[32 +: IN_W];
   assign p = req.data[56 +: IN_W];
   assign first = req.data[80];
   assign last  = req.data[81];
   assign dx = (x > px_ff) ? x - px_ff : px_ff - x;
   assign dy = (y > py_ff) ? y - py_ff : py_ff - y;
   assign sx = dx * dx;
   assign sy = dy * dy;
   assign sq = {1'b0, sx} + {1'b0, sy};
   assign travel = !first && (w != '0 || last);
   assign mv = first || w != '0 || last;
   assign req.ready = q_ready;
   assign q_valid = req.valid;
   assign q_data = {travel, last, first, p, w, sq};

   always_comb begin
      px_in = px_ff; py_in = py_ff;
      if (req.valid && q_ready) begin
         if (last) begin
            px_in = '0; py_in = '0;
         end else if (mv) begin
            px_in = x; py_in = y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0; py_ff <= '0;
      end else begin
         px_ff <= px_in; py_ff <= py_in;
      end
   end
endmodule

FILE: src/tpf_back.sv
// Back: sqrt, speed multiply, serial divide, totals and result register.
// Depends on tpf_pkg and tpf_stream_if.
module tpf_back #(
   parameter int COORD_BITS     = tpf_pkg::COORD_BITS_DEF,
   parameter int TIME_FRAC_BITS = tpf_pkg::TIME_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  logic [2*COORD_BITS+1+tpf_pkg::IN_W*2+2:0] q_data,
   input  logic [tpf_pkg::WORD_W-1:0] capacity,
   input  logic [tpf_pkg::WORD_W-1:0] max_speed,
   input  logic [tpf_pkg::WORD_W-1:0] speed_decay,
   input  logic [tpf_pkg::TIME_W-1:0] max_time,
   tpf_stream_if.source rsp
);
   import tpf_pkg::*;
   localparam int SQ_W = 2*COORD_BITS+1;
   localparam int RT_W = COORD_BITS+1;
   localparam int SQ_STEPS = (SQ_W+1)/2;
   localparam int NUM_W = RT_W + 16 + TIME_FRAC_BITS;
   localparam int DCNT_W = $clog2(NUM_W+1);
   localparam int SCNT_W = $clog2(SQ_STEPS+1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_SQRT = 5'b00010, S_MUL = 5'b00100,
      S_DIV = 5'b01000, S_DONE = 5'b10000
   } state_type;
   state_type st_ff, st_in;

   logic [SQ_W-1:0] sq;
   logic [IN_W-1:0] w, p;
   logic first, last, travel;
   assign sq = q_data[SQ_W-1:0];
   assign w  = q_data[SQ_W +: IN_W];
   assign p  = q_data[SQ_W+IN_W +: IN_W];
   assign first  = q_data[SQ_W+2*IN_W];
   assign last   = q_data[SQ_W+2*IN_W+1];
   assign travel = q_data[SQ_W+2*IN_W+2];

   logic [WORD_W-1:0] cw_ff, cw_in, ws_ff, ws_in, ps_ff, ps_in;
   logic [TIME_W-1:0] et_ff, et_in;
   logic vio_ff, vio_in;
   // latched word
   logic [SQ_W-1:0] sqv_ff, sqv_in;
   logic [IN_W-1:0] wl_ff, wl_in;
   logic last_ff, last_in;
   // sqrt
   logic [SQ_W+1:0] rest_ff, rest_in;
   logic [SQ_W+1:0] root_ff, root_in, bit_ff, bit_in;
   logic [SCNT_W-1:0] scnt_ff, scnt_in;
   // div
   logic [63:0] loss_prod;
   logic [WORD_W-1:0] spd_ff, spd_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [WORD_W:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   // output
   logic rv_ff, rv_in;
   logic [WORD_W*2+TIME_W:0] rd_ff, rd_in;

   logic [WORD_W:0] wsum, psum, csum;
   logic [TIME_W:0] tsum;
   logic [WORD_W-1:0] cw0, ws0, ps0;
   logic [TIME_W-1:0] et0;
   logic vio0;
   logic [SQ_W+1:0] trial;
   logic [WORD_W:0] rsh;
   logic [RT_W-1:0] rootc;
   logic [2*RT_W-1:0] rsq;
   logic [TIME_W-1:0] inc;

   assign rsp.valid = rv_ff;
   assign rsp.data  = rd_ff;
   assign q_ready = (st_ff == S_IDLE) && !(rv_ff && !rsp.ready && q_data[SQ_W+2*IN_W+1]);
   assign loss_prod = speed_decay * cw_ff;
   assign trial = root_ff + bit_ff;
   assign rsh = {rem_ff[WORD_W-1:0], num_ff[NUM_W-1]};
   assign rootc = root_ff[RT_W-1:0];
   assign rsq = rootc * rootc;
   assign inc = (quo_ff > NUM_W'(TIME_ALL)) ? TIME_ALL : TIME_W'(quo_ff);
   assign tsum = {1'b0, et_ff} + {1'b0, inc};

   always_comb begin
      st_in = st_ff; cw_in = cw_ff; ws_in = ws_ff; ps_in = ps_ff;
      et_in = et_ff; vio_in = vio_ff; sqv_in = sqv_ff; wl_in = wl_ff;
      last_in = last_ff; rest_in = rest_ff; root_in = root_ff; bit_in = bit_ff;
      scnt_in = scnt_ff; spd_in = spd_ff; num_in = num_ff; rem_in = rem_ff;
      quo_in = quo_ff; dcnt_in = dcnt_ff; rv_in = rv_ff; rd_in = rd_ff;
      cw0 = first ? '0 : cw_ff; ws0 = first ? '0 : ws_ff;
      ps0 = first ? '0 : ps_ff; et0 = first ? '0 : et_ff;
      vio0 = first ? 1'b0 : vio_ff;
      wsum = {1'b0, ws0} + {{(WORD_W-IN_W+1){1'b0}}, w};
      psum = {1'b0, ps0} + {{(WORD_W-IN_W+1){1'b0}}, p};
      csum = {1'b0, cw_ff} + {{(WORD_W-IN_W+1){1'b0}}, wl_ff};
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (q_valid && q_ready) begin
               cw_in = cw0; et_in = et0;
               ws_in = wsum[WORD_W] ? '1 : wsum[WORD_W-1:0];
               ps_in = psum[WORD_W] ? '1 : psum[WORD_W-1:0];
               vio_in = vio0 | wsum[WORD_W] | (ws_in > capacity);
               sqv_in = sq; wl_in = w; last_in = last;
               if (travel) begin
                  if (cw0 <= capacity) begin
                     rest_in = {2'b0, sq}; root_in = '0;
                     bit_in = (SQ_W+2)'(1) << (2*(SQ_STEPS-1));
                     scnt_in = SCNT_W'(SQ_STEPS);
                     st_in = S_SQRT;
                  end else begin
                     st_in = S_DONE;
                  end
               end else if (last) begin
                  st_in = S_DONE;
               end
            end
         end
         S_SQRT: begin
            if (scnt_ff != '0) begin
               if (rest_ff >= trial) begin
                  rest_in = rest_ff - trial;
                  root_in = (root_ff >> 1) + bit_ff;
               end else begin
                  root_in = root_ff >> 1;
               end
               bit_in = bit_ff >> 2;
               scnt_in = scnt_ff - 1'b1;
            end else begin
               if ((SQ_W+2)'(rsq) < {2'b0, sqv_ff}) root_in = root_ff + 1'b1;
               st_in = S_MUL;
            end
         end
         S_MUL: begin
            if (loss_prod[63:16] >= {16'b0, max_speed}) begin
               vio_in = 1'b1; et_in = TIME_ALL;
               if (TIME_ALL > max_time) vio_in = 1'b1;
               st_in = S_DONE;
            end else begin
               spd_in = max_speed - loss_prod[47:16];
               num_in = NUM_W'(root_ff[RT_W-1:0]) << (16 + TIME_FRAC_BITS);
               rem_in = '0; quo_in = '0;
               dcnt_in = DCNT_W'(NUM_W);
               st_in = S_DIV;
            end
         end
         S_DIV: begin
            if (dcnt_ff != '0) begin
               num_in = num_ff << 1;
               if (rsh >= {1'b0, spd_ff}) begin
                  rem_in = rsh - {1'b0, spd_ff};
                  quo_in = {quo_ff[NUM_W-2:0], 1'b1};
               end else begin
                  rem_in = rsh;
                  quo_in = {quo_ff[NUM_W-2:0], 1'b0};
               end
               dcnt_in = dcnt_ff - 1'b1;
            end else begin
               et_in = tsum[TIME_W] ? TIME_ALL : tsum[TIME_W-1:0];
               if (et_in > max_time) vio_in = 1'b1;
               st_in = S_DONE;
            end
         end
         S_DONE: begin
            cw_in = csum[WORD_W] ? '1 : csum[WORD_W-1:0];
            if (last_ff) begin
               rv_in = 1'b1;
               rd_in = {et_ff, ws_ff, ps_ff, !vio_ff};
               cw_in = '0; ws_in = '0; ps_in = '0; et_in = '0; vio_in = 1'b0;
            end
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      sqv_ff <= sqv_in; wl_ff <= wl_in; rest_ff <= rest_in; root_ff <= root_in;
      bit_ff <= bit_in; spd_ff <= spd_in; num_ff <= num_in; rem_ff <= rem_in;
      quo_ff <= quo_in; rd_ff <= rd_in; last_ff <= last_in;
      if (reset) begin
         st_ff <= S_IDLE; cw_ff <= '0; ws_ff <= '0; ps_ff <= '0; et_ff <= '0;
         vio_ff <= 1'b0; scnt_ff <= '0; dcnt_ff <= '0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cw_ff <= cw_in; ws_ff <= ws_in; ps_ff <= ps_in;
         et_ff <= et_in; vio_ff <= vio_in; scnt_ff <= scnt_in;
         dcnt_ff <= dcnt_in; rv_ff <= rv_in;
      end
   end
endmodule

FILE: src/tour_packing_fitness.sv
// Top level of the tour fitness evaluator.
// Depends on tpf_pkg, tpf_stream_if, tpf_front, tpf_queue, tpf_back.
//
// Takes one tour stop per req word (x, y, picked weight/profit, first/last
// marks) and returns one rsp word per tour on its last stop: feasibility,
// saturating profit and weight totals, and travel time in Q32.16. A stop
// that does not travel is only accepted, and passes through S_DONE too when
// it ends a tour; so does a stop while the knapsack is overloaded. A counted
// stop is accepted, runs an iterative integer square root (COORD_BITS+1
// steps and a rounding step), a speed multiply and a restoring divide (one
// step per quotient bit, then folding in the sum), and finishes in S_DONE.
// The front end computes dx^2+dy^2 and hands words through a two-deep
// queue. A last stop waits at the queue head while an earlier result word
// is still unread. Config registers are written via csr_*; the user must
// write them only while nothing is in flight; the block does not enforce it.
module tour_packing_fitness #(
   parameter int COORD_BITS     = tpf_pkg::COORD_BITS_DEF,
   parameter int TIME_FRAC_BITS = tpf_pkg::TIME_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   tpf_stream_if.sink   req,
   tpf_stream_if.source rsp,
   input  logic                          csr_write_enable,
   input  logic [tpf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tpf_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import tpf_pkg::*;
   localparam int QW = 2*COORD_BITS+1+IN_W*2+3;
   logic [WORD_W-1:0] cap_ff, spd_ff, dec_ff;
   logic [TIME_W-1:0] mt_ff;
   logic fq_valid, fq_ready, bq_valid, bq_ready;
   logic [QW-1:0] fq_data, bq_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= WORD_W'(1000); spd_ff <= WORD_W'(65536);
         dec_ff <= '0; mt_ff <= TIME_ALL;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_CAPACITY:  cap_ff <= csr_write_data[WORD_W-1:0];
            REG_MAX_SPEED: spd_ff <= csr_write_data[WORD_W-1:0];
            REG_DECAY:     dec_ff <= csr_write_data[WORD_W-1:0];
            REG_MAX_TIME:  mt_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   tpf_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock, .reset, .req,
      .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
   );

   tpf_queue #(.W(QW)) u_queue (
      .clock, .reset,
      .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
      .out_valid(bq_valid), .out_ready(bq_ready), .out_data(bq_data)
   );

   tpf_back #(.COORD_BITS(COORD_BITS), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_back (
      .clock, .reset,
      .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
      .capacity(cap_ff), .max_speed(spd_ff), .speed_decay(dec_ff),
      .max_time(mt_ff), .rsp
   );
endmodule

FILE: tb/sv/tpf_tb_pkg.sv
`timescale 1ns / 1ps
// Word layouts shared by the tour fitness testbench and its checker.
// Depends on tpf_pkg.
package tpf_tb_pkg;
   import tpf_pkg::*;

   // first member is the top bits: x sits at bit 0
   typedef struct packed {
      logic            last;
      logic            first;
      logic [IN_W-1:0] profit;
      logic [IN_W-1:0] weight;
      logic [15:0]     y;
      logic [15:0]     x;
   } stop_t;

   typedef struct packed {
      logic [TIME_W-1:0] travel;
      logic [WORD_W-1:0] weight;
      logic [WORD_W-1:0] profit;
      logic              feasible;
   } verdict_t;

   localparam int STOP_W    = $bits(stop_t);
   localparam int VERDICT_W = $bits(verdict_t);
endpackage

FILE: tb/sv/tpf_checker.sv
`timescale 1ns / 1ps
// Checker for tour_packing_fitness: watches req, rsp and csr, predicts verdicts.
// Depends on tpf_pkg and tpf_tb_pkg.
module tpf_checker
   import tpf_pkg::*;
   import tpf_tb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [STOP_W-1:0]     req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [VERDICT_W-1:0]  rsp_data,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    fail_count,
   output int                    outstanding,
   output int                    verdicts_seen
);
   localparam logic [63:0] MAX32 = 64'hFFFF_FFFF;
   localparam logic [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;

   logic [63:0] cap, vmax, decay, tlimit;
   logic [15:0] pos_x, pos_y;
   logic [63:0] load, w_acc, p_acc, t_acc;
   logic        broken;
   verdict_t    pending_verdicts[$];

   function automatic logic [63:0] root_up(logic [63:0] v);
      logic [63:0] r;
      r = 0;
      for (int b = 17; b >= 0; b--)
         if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r = r | (64'd1 << b);
      if (r * r < v) r = r + 1;
      return r;
   endfunction

   function automatic void clear_tour();
      pos_x = 0; pos_y = 0; load = 0; w_acc = 0; p_acc = 0; t_acc = 0; broken = 0;
   endfunction

   function automatic void fold_stop(stop_t s);
      logic [63:0] dx, dy, span, loss, inc;
      verdict_t v;
      if (s.first) clear_tour();
      w_acc = w_acc + s.weight;
      if (w_acc > MAX32) begin
         w_acc = MAX32;
         broken = 1;
      end
      if (w_acc > cap) broken = 1;
      p_acc = p_acc + s.profit;
      if (p_acc > MAX32) p_acc = MAX32;
      if (!s.first && (s.weight != 0 || s.last)) begin
         // an overloaded knapsack does not move the clock
         if (load <= cap) begin
            dx = (s.x > pos_x) ? s.x - pos_x : pos_x - s.x;
            dy = (s.y > pos_y) ? s.y - pos_y : pos_y - s.y;
            span = root_up(dx * dx + dy * dy);
            loss = (decay * load) >> 16;
            if (loss >= vmax) begin
               broken = 1;
               t_acc = MAX48;
            end else begin
               inc = (span << 32) / (vmax - loss);
               if (inc > MAX48) inc = MAX48;
               t_acc = t_acc + inc;
               if (t_acc > MAX48) t_acc = MAX48;
            end
            if (t_acc > tlimit) broken = 1;
         end
         load = load + s.weight;
         if (load > MAX32) load = MAX32;
      end
      if (s.first || s.weight != 0 || s.last) begin
         pos_x = s.x;
         pos_y = s.y;
      end
      if (s.last) begin
         v.feasible = !broken;
         v.profit = p_acc[31:0];
         v.weight = w_acc[31:0];
         v.travel = t_acc[47:0];
         pending_verdicts = {pending_verdicts, v};
         clear_tour();
      end
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      verdict_t got, want;
      if (reset) begin
         cap = 1000; vmax = 65536; decay = 0; tlimit = MAX48;
         clear_tour();
         pending_verdicts.delete();
      end else begin
         if (csr_write_enable)
            case (csr_index)
               REG_CAPACITY:  cap = csr_write_data[31:0];
               REG_MAX_SPEED: vmax = csr_write_data[31:0];
               REG_DECAY:     decay = csr_write_data[31:0];
               REG_MAX_TIME:  tlimit = csr_write_data[47:0];
               default: ;
            endcase
         if (req_valid && req_ready) fold_stop(stop_t'(req_data));
         if (rsp_valid && rsp_ready) begin
            got = verdict_t'(rsp_data);
            verdicts_seen++;
            if (pending_verdicts.size() == 0) begin
               report("verdict with none pending", got.travel, 0);
            end else begin
               want = pending_verdicts.pop_front();
               if (got.feasible != want.feasible)
                  report("feasible", got.feasible, want.feasible);
               if (got.profit != want.profit) report("profit sum", got.profit, want.profit);
               if (got.weight != want.weight) report("weight sum", got.weight, want.weight);
               if (got.travel != want.travel) report("travel_time", got.travel, want.travel);
            end
         end
      end
      outstanding <= pending_verdicts.size();
   end

   initial begin
      fail_count = 0;
      outstanding = 0;
      verdicts_seen = 0;
   end
endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the tour fitness testbench: clock, reset, stimulus and verdict.
// Depends on tpf_pkg, tpf_tb_pkg, tpf_stream_if, tpf_checker, tour_packing_fitness.
module testbench;
   import tpf_pkg::*;
   import tpf_tb_pkg::*;

   localparam int IDLE_LIMIT = 5000;  // cycles with no handshake at all
   localparam int DRAIN_WAIT = 300;   // up to three stops still in flight
   localparam int SQUEEZE_CYCLES = 400;

   logic clock = 0;
   logic reset = 1;
   logic                  csr_write_enable = 0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_CAPACITY;
   logic [CSR_DATA_W-1:0] csr_write_data = 0;
   logic calm = 0;     // no idling on either side
   logic squeeze = 0;  // ask the receiver for one long hold-off

   int fail_count, outstanding, verdicts_seen;
   int stops_sent = 0;
   int idle_cycles = 0;
   logic [15:0] last_x = 0, last_y = 0;

   tpf_stream_if #(.W(STOP_W))    req_ch ();
   tpf_stream_if #(.W(VERDICT_W)) rsp_ch ();

   tour_packing_fitness DUT (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   tpf_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .fail_count(fail_count), .outstanding(outstanding), .verdicts_seen(verdicts_seen)
   );

   always #4 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.data = '0;
      rsp_ch.ready = 0;
   end

   // receiver: random stalls, one long hold-off on request
   always @(negedge clock) begin
      if (squeeze) begin
         rsp_ch.ready = 0;
         repeat (SQUEEZE_CYCLES) @(negedge clock);
         squeeze = 0;
      end
      rsp_ch.ready = calm || ($urandom_range(99) >= 12);
   end

   // watchdog: nothing moving for too long means the block is stuck
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_write_enable)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake in %0d cycles", IDLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_write_enable = 1;
      csr_index = idx;
      csr_write_data = val;
      @(negedge clock);
      csr_write_enable = 0;
   endtask

   task automatic load_regs(logic [31:0] c, logic [31:0] s, logic [31:0] d, logic [47:0] t);
      write_reg(REG_CAPACITY, CSR_DATA_W'(c));
      write_reg(REG_MAX_SPEED, CSR_DATA_W'(s));
      write_reg(REG_DECAY, CSR_DATA_W'(d));
      write_reg(REG_MAX_TIME, CSR_DATA_W'(t));
   endtask

   // one word onto req; valid stays high across back-to-back words
   task automatic send_stop(stop_t s);
      if (!calm && $urandom_range(99) < 12) begin
         req_ch.valid = 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_ch.valid = 1;
      req_ch.data = s;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      stops_sent++;
   endtask

   task automatic stop_at(logic [15:0] x, logic [15:0] y, logic [23:0] w, logic [23:0] p,
                          logic f, logic l);
      stop_t s;
      s = '{x: x, y: y, weight: w, profit: p, first: f, last: l};
      send_stop(s);
   endtask

   // wait for every verdict, then give a stop still in flight time to finish
   task automatic drain();
      req_ch.valid = 0;
      while (outstanding != 0 || u_checker.pending_verdicts.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   function automatic logic [23:0] pick_weight(logic [31:0] cap);
      int r;
      r = $urandom_range(99);
      if (r < 25) return '0;
      if (r < 75) return 24'($urandom_range(1, (cap > 32'd4000) ? 500 : (cap / 4 + 1)));
      if (r < 92) return 24'($urandom);
      return 24'hFFFFFF;
   endfunction

   function automatic logic [15:0] pick_coord(logic [15:0] near);
      if ($urandom_range(3) == 0) return 16'(near + $urandom_range(0, 300));
      return 16'($urandom);
   endfunction

   // mostly well-formed tours; some words with random marks as noise
   task automatic random_stops(int count, logic [31:0] cap, int max_len);
      int n, len;
      stop_t s;
      n = 0;
      while (n < count) begin
         len = $urandom_range(1, max_len);
         for (int i = 0; i < len; i++) begin
            s.x = pick_coord(last_x);
            s.y = pick_coord(last_y);
            s.weight = pick_weight(cap);
            s.profit = ($urandom_range(9) == 0) ? 24'hFFFFFF : 24'($urandom);
            s.first = (i == 0);
            s.last = (i == len - 1);
            if ($urandom_range(99) < 8) begin
               s.first = 1'($urandom);
               s.last = 1'($urandom);
            end
            last_x = s.x;
            last_y = s.y;
            send_stop(s);
            n++;
         end
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset = 0;

      // directed, default registers
      stop_at(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 1, 1);   // one-stop tour
      stop_at(0, 0, 0, 5, 1, 0);
      stop_at(16'hFFFF, 16'hFFFF, 10, 7, 0, 0);                    // longest hop
      stop_at(3, 4, 0, 1, 0, 0);                                   // zero weight, skipped
      stop_at(0, 0, 0, 2, 0, 1);                                   // zero weight but last
      stop_at(100, 200, 40, 9, 0, 1);                              // tour with no first stop
      stop_at(5, 5, 20, 1, 1, 0);
      stop_at(9, 8, 30, 1, 0, 0);
      stop_at(1, 1, 2, 3, 1, 0);                                   // restart mid-tour
      stop_at(7, 7, 24'hFFFFFF, 0, 0, 0);                          // over capacity
      stop_at(90, 90, 1, 0, 0, 0);                                 // overloaded: no travel
      stop_at(0, 90, 0, 0, 0, 1);
      for (int i = 0; i < 3; i++)                                  // weight sum overflows
         stop_at(16'(i), 16'(i), 24'hFFFFFF, 24'hFFFFFF, i == 0, 0);
      for (int i = 0; i < 300; i++)
         stop_at(16'(i), 0, 24'hFFFFFF, 24'hFFFFFF, 0, 0);
      stop_at(0, 0, 0, 0, 0, 1);
      drain();

      // crawling speed saturates the clock; huge capacity
      load_regs(32'hFFFF_FFFF, 1, 0, TIME_ALL);
      stop_at(0, 0, 0, 0, 1, 0);
      stop_at(16'hFFFF, 16'hFFFF, 1, 0, 0, 1);
      random_stops(150, 32'hFFFF_FFFF, 6);
      drain();

      // decay eats the whole speed; time limit zero
      load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      stop_at(10, 10, 0, 0, 1, 0);
      stop_at(20, 10, 24'hFFFFFF, 0, 0, 0);
      stop_at(30, 10, 1, 0, 0, 1);
      random_stops(150, 32'hFFFF_FFFF, 6);
      drain();

      // fill-up: short tours while the receiver holds off
      load_regs(1, 32'h0001_0000, 0, 48'h0000_1000_0000);
      squeeze = 1;
      random_stops(60, 1, 1);
      random_stops(150, 1, 6);
      drain();

      // no idling on either side
      calm = 1;
      load_regs(5000, 32'h0004_0000, 32'h0000_0400, 48'h0010_0000_0000);
      random_stops(250, 5000, 8);
      drain();
      calm = 0;

      for (int k = 0; k < 6; k++) begin
         logic [31:0] c;
         c = ($urandom_range(1) == 0) ? $urandom_range(1, 20000) : $urandom;
         if (c == 0) c = 1;
         load_regs(c, $urandom_range(1, 32'h0008_0000) | ($urandom_range(3) == 0 ? $urandom : 0),
                   ($urandom_range(2) == 0) ? 0 : $urandom_range(0, 32'h0001_0000),
                   {16'($urandom_range(0, 16'hFFFF)), $urandom});
         random_stops(90, c, 8);
         drain();
      end

      load_regs(1000, 65536, 0, TIME_ALL);

      $display("run covered %0d stops and %0d tour verdicts across 11 register settings",
               stops_sent, verdicts_seen);
      $display("including saturation, stalled speed, overload and a long receiver hold-off");
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
